>>> hw/rtl/psmft_pkg.sv
// Package for the power stage measurement filter and trip block.
// Holds register map codes, reset values and fixed widths.
// No dependencies.
package psmft_pkg;

	localparam int POWER_WIDTH = 40;
	localparam int ALPHA_WIDTH = 17;
	localparam int LIMIT_WIDTH = 19;
	localparam int ALPHA_OPW   = ALPHA_WIDTH + 1;
	localparam int ADDR_WIDTH  = 5;
	localparam int DATA_WIDTH  = 32;
	localparam int FRAC_BITS   = 16;

	localparam logic [ALPHA_WIDTH-1:0] ALPHA_ONE   = 17'd65536;
	localparam logic [ALPHA_WIDTH-1:0] ALPHA_RESET = 17'd13107;
	localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = 19'd524287;

	typedef enum logic [2:0] {
		REG_ALPHA     = 3'd0,
		REG_PRIM_ILIM = 3'd1,
		REG_PRIM_VLIM = 3'd2,
		REG_SEC_ILIM  = 3'd3,
		REG_SEC_VLIM  = 3'd4
	} reg_idx_t;

	localparam logic CMD_CLEAR = 1'b1;

endpackage

>>> hw/rtl/power_stage_measurement_filter_and_trip.sv
// Top level of the power stage measurement filter and trip block.
// Depends on psmft_pkg for register codes, reset values and widths.
//
// Usage: a request carries one measurement set (cmd = 0) or a clear of the
// trip flag and both powers (cmd = 1) on the in_valid/in_ready channel.
// Each request yields exactly one result on out_valid/out_ready: four
// filtered currents, input and output power and the trip flag. Limits and
// alpha are to be set through the APB-style port while the block is idle;
// the block itself does not enforce this. pready is always high.
// A measurement set runs through one shared signed multiplier under a step
// counter: four filter products, then the two power products, one issued
// per cycle with the product registered. The result then passes the HOLD
// state into the output register; a clear goes straight to HOLD. in_ready
// is high only while no request is in flight, so a new request is taken
// only after the last one has reached the output register.
// If the receiver stalls, the finished result waits in the output register
// and the next request may be taken; its result then waits internally until
// the output register frees, and in_ready stays low meanwhile.
// Reset clears averages and trip flag, loads the default alpha and limits,
// and empties the output register.
module power_stage_measurement_filter_and_trip import psmft_pkg::*; #(
	parameter int SAMPLE_WIDTH = 20
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ADDR_WIDTH-1:0]         paddr,
	input  logic [DATA_WIDTH-1:0]         pwdata,
	output logic [DATA_WIDTH-1:0]         prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          cmd,
	input  logic signed [SAMPLE_WIDTH-1:0] in_current,
	input  logic signed [SAMPLE_WIDTH-1:0] prim_current,
	input  logic signed [SAMPLE_WIDTH-1:0] in_voltage,
	input  logic signed [SAMPLE_WIDTH-1:0] in_dc_voltage,
	input  logic signed [SAMPLE_WIDTH-1:0] prim_cap_voltage,
	input  logic signed [SAMPLE_WIDTH-1:0] out_current,
	input  logic signed [SAMPLE_WIDTH-1:0] sec_current,
	input  logic signed [SAMPLE_WIDTH-1:0] out_voltage,
	input  logic signed [SAMPLE_WIDTH-1:0] out_dc_voltage,
	input  logic signed [SAMPLE_WIDTH-1:0] sec_cap_voltage,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [SAMPLE_WIDTH-1:0] in_current_avg,
	output logic signed [SAMPLE_WIDTH-1:0] prim_current_avg,
	output logic signed [SAMPLE_WIDTH-1:0] out_current_avg,
	output logic signed [SAMPLE_WIDTH-1:0] sec_current_avg,
	output logic signed [POWER_WIDTH-1:0]  power_in,
	output logic signed [POWER_WIDTH-1:0]  power_out,
	output logic                          tripped
);

	localparam int SW  = SAMPLE_WIDTH;
	localparam int OPW = (SW + 1 > ALPHA_OPW) ? SW + 1 : ALPHA_OPW;
	localparam int PRW = 2 * OPW;
	localparam int EXW = (PRW + 1 > POWER_WIDTH + 1) ? PRW + 1 : POWER_WIDTH + 1;
	localparam int CW  = ((SW > LIMIT_WIDTH) ? SW : LIMIT_WIDTH) + 2;

	localparam logic signed [EXW-1:0] AVG_MAX = EXW'((64'sd1 <<< (SW - 1)) - 64'sd1);
	localparam logic signed [EXW-1:0] AVG_MIN = -AVG_MAX - EXW'(1);
	localparam logic signed [EXW-1:0] POW_MAX =
		EXW'((64'sd1 <<< (POWER_WIDTH - 1)) - 64'sd1);
	localparam logic signed [EXW-1:0] POW_MIN = -POW_MAX - EXW'(1);
	localparam logic signed [EXW-1:0] RND_HALF = EXW'(64'sd1 <<< (FRAC_BITS - 1));

	// step codes: a step issues one product and retires the previous one
	localparam logic [2:0] ST_EMA_PRIM = 3'd0;
	localparam logic [2:0] ST_EMA_IN   = 3'd1;
	localparam logic [2:0] ST_EMA_OUT  = 3'd2;
	localparam logic [2:0] ST_EMA_SEC  = 3'd3;
	localparam logic [2:0] ST_POW_IN   = 3'd4;
	localparam logic [2:0] ST_POW_OUT  = 3'd5;
	localparam logic [2:0] ST_LAST     = 3'd6;

	typedef enum logic [1:0] {IDLE, RUN, HOLD} state_t;

	state_t state_q;
	logic [2:0] step_q;

	logic [ALPHA_WIDTH-1:0] alpha_q;
	logic [LIMIT_WIDTH-1:0] prim_ilim_q, prim_vlim_q, sec_ilim_q, sec_vlim_q;

	logic signed [SW-1:0] in_cur_q, prim_cur_q, in_volt_q, in_dc_q, prim_cap_q;
	logic signed [SW-1:0] out_cur_q, sec_cur_q, out_volt_q, out_dc_q, sec_cap_q;

	logic signed [SW-1:0] in_avg_q, prim_avg_q, out_avg_q, sec_avg_q;
	logic signed [POWER_WIDTH-1:0] pin_q, pout_q;
	logic trip_q;

	logic signed [SW-1:0] o_in_avg_q, o_prim_avg_q, o_out_avg_q, o_sec_avg_q;
	logic signed [POWER_WIDTH-1:0] o_pin_q, o_pout_q;
	logic o_trip_q, o_valid_q;

	logic signed [OPW-1:0] op_a, op_b;
	logic signed [PRW-1:0] prod_q;
	logic signed [SW-1:0]  ema_x, ema_avg;
	logic signed [SW:0]    ema_diff;
	logic [ALPHA_WIDTH-1:0] alpha_eff;
	logic signed [EXW-1:0] prod_ext, ema_sum, ema_sat, pow_sat;
	logic signed [SW-1:0]  ret_avg;
	logic violation;
	logic in_acc, cfg_wr, out_free;

	assign pready   = 1'b1;
	assign in_ready = (state_q == IDLE);
	assign in_acc   = in_valid && in_ready;
	assign cfg_wr   = psel && penable && pwrite;
	assign out_free = !o_valid_q || out_ready;

	assign out_valid        = o_valid_q;
	assign in_current_avg   = o_in_avg_q;
	assign prim_current_avg = o_prim_avg_q;
	assign out_current_avg  = o_out_avg_q;
	assign sec_current_avg  = o_sec_avg_q;
	assign power_in         = o_pin_q;
	assign power_out        = o_pout_q;
	assign tripped          = o_trip_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q     <= ALPHA_RESET;
			prim_ilim_q <= LIMIT_RESET;
			prim_vlim_q <= LIMIT_RESET;
			sec_ilim_q  <= LIMIT_RESET;
			sec_vlim_q  <= LIMIT_RESET;
		end else if (cfg_wr) begin
			case (paddr[4:2])
				REG_ALPHA:     alpha_q     <= pwdata[ALPHA_WIDTH-1:0];
				REG_PRIM_ILIM: prim_ilim_q <= pwdata[LIMIT_WIDTH-1:0];
				REG_PRIM_VLIM: prim_vlim_q <= pwdata[LIMIT_WIDTH-1:0];
				REG_SEC_ILIM:  sec_ilim_q  <= pwdata[LIMIT_WIDTH-1:0];
				REG_SEC_VLIM:  sec_vlim_q  <= pwdata[LIMIT_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			REG_ALPHA:     prdata = DATA_WIDTH'(alpha_q);
			REG_PRIM_ILIM: prdata = DATA_WIDTH'(prim_ilim_q);
			REG_PRIM_VLIM: prdata = DATA_WIDTH'(prim_vlim_q);
			REG_SEC_ILIM:  prdata = DATA_WIDTH'(sec_ilim_q);
			REG_SEC_VLIM:  prdata = DATA_WIDTH'(sec_vlim_q);
			default:       prdata = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			in_cur_q   <= in_current;
			prim_cur_q <= prim_current;
			in_volt_q  <= in_voltage;
			in_dc_q    <= in_dc_voltage;
			prim_cap_q <= prim_cap_voltage;
			out_cur_q  <= out_current;
			sec_cur_q  <= sec_current;
			out_volt_q <= out_voltage;
			out_dc_q   <= out_dc_voltage;
			sec_cap_q  <= sec_cap_voltage;
		end
	end

	// operand select for the shared multiplier
	assign alpha_eff = (alpha_q > ALPHA_ONE) ? ALPHA_ONE : alpha_q;

	always_comb begin
		case (step_q)
			ST_EMA_PRIM: begin ema_x = prim_cur_q; ema_avg = prim_avg_q; end
			ST_EMA_IN:   begin ema_x = in_cur_q;   ema_avg = in_avg_q;   end
			ST_EMA_OUT:  begin ema_x = out_cur_q;  ema_avg = out_avg_q;  end
			default:     begin ema_x = sec_cur_q;  ema_avg = sec_avg_q;  end
		endcase
		ema_diff = (SW + 1)'(ema_x) - (SW + 1)'(ema_avg);
		case (step_q)
			ST_POW_IN: begin
				op_a = OPW'(prim_cur_q);
				op_b = OPW'(in_dc_q);
			end
			ST_POW_OUT: begin
				op_a = OPW'(out_avg_q);
				op_b = OPW'(out_dc_q);
			end
			default: begin
				op_a = OPW'(signed'({1'b0, alpha_eff}));
				op_b = OPW'(ema_diff);
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= op_a * op_b;
	end

	// retire the product issued in the previous step
	always_comb begin
		case (step_q)
			ST_EMA_IN:  ret_avg = prim_avg_q;
			ST_EMA_OUT: ret_avg = in_avg_q;
			ST_EMA_SEC: ret_avg = out_avg_q;
			default:    ret_avg = sec_avg_q;
		endcase
		prod_ext = EXW'(prod_q);
		ema_sum  = ((prod_ext + RND_HALF) >>> FRAC_BITS) + EXW'(ret_avg);
		if (ema_sum > AVG_MAX)
			ema_sat = AVG_MAX;
		else if (ema_sum < AVG_MIN)
			ema_sat = AVG_MIN;
		else
			ema_sat = ema_sum;
		if (prod_ext > POW_MAX)
			pow_sat = POW_MAX;
		else if (prod_ext < POW_MIN)
			pow_sat = POW_MIN;
		else
			pow_sat = prod_ext;
	end

	function automatic logic outside_sym(input logic signed [SW-1:0] x,
			input logic [LIMIT_WIDTH-1:0] lim);
		logic signed [CW-1:0] xe;
		logic signed [CW-1:0] le;
		xe = CW'(x);
		le = CW'(signed'({1'b0, lim}));
		return (xe > le) || (xe < -le);
	endfunction

	function automatic logic above(input logic signed [SW-1:0] x,
			input logic [LIMIT_WIDTH-1:0] lim);
		return CW'(x) > CW'(signed'({1'b0, lim}));
	endfunction

	assign violation =
		outside_sym(in_cur_q, prim_ilim_q) || outside_sym(prim_cur_q, prim_ilim_q) ||
		above(in_volt_q, prim_vlim_q) || above(in_dc_q, prim_vlim_q) ||
		above(prim_cap_q, prim_vlim_q) ||
		outside_sym(sec_cur_q, sec_ilim_q) ||
		above(out_volt_q, sec_vlim_q) || above(out_dc_q, sec_vlim_q) ||
		above(sec_cap_q, sec_vlim_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= IDLE;
			step_q     <= ST_EMA_PRIM;
			in_avg_q   <= '0;
			prim_avg_q <= '0;
			out_avg_q  <= '0;
			sec_avg_q  <= '0;
			pin_q      <= '0;
			pout_q     <= '0;
			trip_q     <= 1'b0;
			o_valid_q  <= 1'b0;
			o_in_avg_q   <= '0;
			o_prim_avg_q <= '0;
			o_out_avg_q  <= '0;
			o_sec_avg_q  <= '0;
			o_pin_q      <= '0;
			o_pout_q     <= '0;
			o_trip_q     <= 1'b0;
		end else begin
			if (o_valid_q && out_ready && state_q != HOLD)
				o_valid_q <= 1'b0;
			case (state_q)
				IDLE: begin
					if (in_acc) begin
						if (cmd == CMD_CLEAR) begin
							trip_q  <= 1'b0;
							pin_q   <= '0;
							pout_q  <= '0;
							state_q <= HOLD;
						end else begin
							step_q  <= ST_EMA_PRIM;
							state_q <= RUN;
						end
					end
				end
				RUN: begin
					case (step_q)
						ST_EMA_IN:  prim_avg_q <= ema_sat[SW-1:0];
						ST_EMA_OUT: in_avg_q   <= ema_sat[SW-1:0];
						ST_EMA_SEC: out_avg_q  <= ema_sat[SW-1:0];
						ST_POW_IN:  sec_avg_q  <= ema_sat[SW-1:0];
						ST_POW_OUT: pin_q      <= pow_sat[POWER_WIDTH-1:0];
						ST_LAST: begin
							pout_q <= pow_sat[POWER_WIDTH-1:0];
							if (violation)
								trip_q <= 1'b1;
						end
						default: ;
					endcase
					if (step_q == ST_LAST)
						state_q <= HOLD;
					else
						step_q <= step_q + 3'd1;
				end
				HOLD: begin
					if (out_free) begin
						o_in_avg_q   <= in_avg_q;
						o_prim_avg_q <= prim_avg_q;
						o_out_avg_q  <= out_avg_q;
						o_sec_avg_q  <= sec_avg_q;
						o_pin_q      <= pin_q;
						o_pout_q     <= pout_q;
						o_trip_q     <= trip_q;
						o_valid_q    <= 1'b1;
						state_q      <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

endmodule
